// ===== rtl/core/rotation_matrix_to_quaternion_macros.svh =====
// Assertion helpers for the asserting file of the block
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define RMQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define RMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rmq_pkg.sv =====
package rmq_pkg;

  // Output slot that receives the half root
  typedef enum logic [1:0] {
    SLOT_X = 2'd0,
    SLOT_Y = 2'd1,
    SLOT_Z = 2'd2,
    SLOT_W = 2'd3
  } slot_t;

  // Classification carried from front to back
  typedef struct packed {
    logic  degen;
    slot_t root;
  } ctrl_t;

  localparam int FIFO_DEPTH = 4;

endpackage

// ===== rtl/core/rmq_front.sv =====
module rmq_front #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [9*W-1:0]       in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [W:0]           s_val,
  output logic [2:0][W:0]      d_val,
  output rmq_pkg::ctrl_t       ctrl
);
  import rmq_pkg::*;

  localparam int EW = W + 2;
  localparam int F  = W - 2;
  localparam logic signed [EW-1:0] ONE_E = EW'(1) << F;

  logic signed [W-1:0]  m [9];
  logic signed [EW-1:0] e [9];
  logic signed [W:0]    f [9];
  logic signed [EW-1:0] trace;
  logic signed [EW-1:0] s_sel;
  logic                 tr_pos;
  logic                 sel1;
  logic                 sel2;
  logic signed [W-1:0]  diag_i;
  slot_t                pivot;
  slot_t                root_c;
  logic signed [W:0]    d_c [3];
  logic                 degen_c;
  logic                 take;

  // Unpack and sign-extend the elements
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m[i] = in_data[i*W +: W];
      e[i] = {{2{m[i][W-1]}}, m[i]};
      f[i] = {m[i][W-1], m[i]};
    end
  end

  // Trace test and pivot pick, ties to the lower axis
  always_comb begin
    trace  = e[0] + e[4] + e[8];
    tr_pos = !trace[EW-1] && (trace != '0);
    sel1   = m[4] > m[0];
    diag_i = sel1 ? m[4] : m[0];
    sel2   = m[8] > diag_i;
    if (sel2) begin
      pivot = SLOT_Z;
    end else if (sel1) begin
      pivot = SLOT_Y;
    end else begin
      pivot = SLOT_X;
    end
  end

  // Route radicand and the three divided terms in ascending slot order
  always_comb begin
    root_c = SLOT_W;
    s_sel  = trace + ONE_E;
    d_c[0] = f[7] - f[5];
    d_c[1] = f[2] - f[6];
    d_c[2] = f[3] - f[1];
    if (!tr_pos) begin
      root_c = pivot;
      unique case (pivot)
        SLOT_X: begin
          s_sel  = e[0] - e[4] - e[8] + ONE_E;
          d_c[0] = f[3] + f[1];
          d_c[1] = f[6] + f[2];
          d_c[2] = f[7] - f[5];
        end
        SLOT_Y: begin
          s_sel  = e[4] - e[8] - e[0] + ONE_E;
          d_c[0] = f[1] + f[3];
          d_c[1] = f[7] + f[5];
          d_c[2] = f[2] - f[6];
        end
        SLOT_Z: begin
          s_sel  = e[8] - e[0] - e[4] + ONE_E;
          d_c[0] = f[2] + f[6];
          d_c[1] = f[5] + f[7];
          d_c[2] = f[3] - f[1];
        end
        default: begin
          s_sel  = e[8] - e[0] - e[4] + ONE_E;
          d_c[0] = f[2] + f[6];
          d_c[1] = f[5] + f[7];
          d_c[2] = f[3] - f[1];
        end
      endcase
    end
    degen_c = !tr_pos && (s_sel[EW-1] || (s_sel == '0));
  end

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Hold the classified beat until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s_val      <= s_sel[W:0];
      d_val[0]   <= d_c[0];
      d_val[1]   <= d_c[1];
      d_val[2]   <= d_c[2];
      ctrl.degen <= degen_c;
      ctrl.root  <= root_c;
    end
  end

endmodule

// ===== rtl/core/rmq_fifo.sv =====
module rmq_fifo #(
  parameter int FW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [FW-1:0] din,
  output logic          full,
  input  logic          pop,
  output logic [FW-1:0] dout,
  output logic          empty
);
  import rmq_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [FW-1:0]    slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(FIFO_DEPTH);
  assign empty = count == '0;
  assign dout  = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the beat
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// ===== rtl/core/rmq_sqrt.sv =====
module rmq_sqrt #(
  parameter int W  = 32,
  parameter int PW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*W-3:0]    n_in,
  input  logic [PW-1:0]     pay_in,
  output logic              out_valid,
  output logic [W-2:0]      root_out,
  output logic [PW-1:0]     pay_out
);
  localparam int NW  = 2 * W - 2;
  localparam int RW  = W - 1;
  localparam int RMW = RW + 2;

  logic [RMW-1:0] rem_r  [RW];
  logic [RW-1:0]  root_r [RW];
  logic [NW-1:0]  n_r    [RW];
  logic [PW-1:0]  pay_r  [RW];
  logic           vld_r  [RW];

  // One root bit per stage, two radicand bits brought down each time
  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic [RMW-1:0] rem_s;
    logic [RW-1:0]  root_s;
    logic [NW-1:0]  n_s;
    logic [PW-1:0]  pay_s;
    logic           vld_s;
    logic [RMW+1:0] cur;
    logic [RMW+1:0] trial;
    logic           fit;

    if (g == 0) begin : g_src0
      assign rem_s  = '0;
      assign root_s = '0;
      assign n_s    = n_in;
      assign pay_s  = pay_in;
      assign vld_s  = in_valid;
    end else begin : g_srcn
      assign rem_s  = rem_r[g-1];
      assign root_s = root_r[g-1];
      assign n_s    = n_r[g-1];
      assign pay_s  = pay_r[g-1];
      assign vld_s  = vld_r[g-1];
    end

    assign cur   = {rem_s, n_s[NW-1:NW-2]};
    assign trial = {2'b00, root_s, 2'b01};
    assign fit   = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= fit ? RMW'(cur - trial) : RMW'(cur);
        root_r[g] <= {root_s[RW-2:0], fit};
        n_r[g]    <= {n_s[NW-3:0], 2'b00};
        pay_r[g]  <= pay_s;
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign root_out  = root_r[RW-1];
  assign pay_out   = pay_r[RW-1];

endmodule

// ===== rtl/core/rmq_div.sv =====
module rmq_div #(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [W-2:0]       h_in,
  input  logic [2:0][W:0]    d_in,
  input  rmq_pkg::ctrl_t     ctrl_in,
  output logic               out_valid,
  output logic [W-2:0]       h_out,
  output rmq_pkg::ctrl_t     ctrl_out,
  output logic [2:0][W-1:0]  q_out,
  output logic [2:0]         ov_out,
  output logic [2:0]         neg_out
);
  import rmq_pkg::*;

  localparam int RW  = W - 1;
  localparam int NNW = 2 * W - 3;
  localparam int NS  = W + 1;

  logic [2:0][RW-1:0] rem_r  [NS];
  logic [2:0][W-1:0]  lo_r   [NS];
  logic [2:0]         ov_r   [NS];
  logic [2:0]         neg_r  [NS];
  logic [RW-1:0]      h_r    [NS];
  ctrl_t              ctrl_r [NS];
  logic               vld_r  [NS];

  // Prepare: magnitude, overflow check against h at the top quotient bit
  logic [2:0][W:0]     mag0;
  logic [2:0][NNW-1:0] num0;
  logic [2:0][RW-1:0]  top0;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag0[l] = d_in[l][W] ? (W+1)'(1'b0) - d_in[l] : d_in[l];
      num0[l] = {mag0[l], {(W - 4){1'b0}}};
      top0[l] = {2'b00, num0[l][NNW-1:W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l] <= top0[l];
        lo_r[0][l]  <= num0[l][W-1:0];
        ov_r[0][l]  <= top0[l] >= h_in;
        neg_r[0][l] <= d_in[l][W];
      end
      h_r[0]    <= h_in;
      ctrl_r[0] <= ctrl_in;
    end
  end

  // One quotient bit per stage in each of the three lanes
  for (genvar g = 1; g < NS; g++) begin : g_stage
    logic [2:0][RW:0]   cur;
    logic [2:0]         fit;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        cur[l] = {rem_r[g-1][l], lo_r[g-1][l][W-1]};
        fit[l] = cur[l] >= {1'b0, h_r[g-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_r[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          rem_r[g][l] <= fit[l] ? RW'(cur[l] - {1'b0, h_r[g-1]}) : RW'(cur[l]);
          lo_r[g][l]  <= {lo_r[g-1][l][W-2:0], fit[l]};
        end
        ov_r[g]   <= ov_r[g-1];
        neg_r[g]  <= neg_r[g-1];
        h_r[g]    <= h_r[g-1];
        ctrl_r[g] <= ctrl_r[g-1];
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign h_out     = h_r[NS-1];
  assign ctrl_out  = ctrl_r[NS-1];
  assign q_out     = lo_r[NS-1];
  assign ov_out    = ov_r[NS-1];
  assign neg_out   = neg_r[NS-1];

endmodule

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion by the trace method, signed Q1.(DATA_WIDTH-2)
// in and out. One matrix is taken per cycle and one quaternion leaves per cycle
// while the output does not stall. Each beat passes one classify stage, the
// four-entry queue, DATA_WIDTH-1 square-root stages, DATA_WIDTH+1 divider stages
// and the output register, in that order. The square-root and divider pipelines
// step together and hold only while a finished result waits on m_axis_tready.
// Components saturate to +/-1.0; a non-positive radicand or a zero root sets
// tuser and zeros the data.
module rotation_matrix_to_quaternion #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, zero fill
  input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]          s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // quat_x, quat_y, quat_z, quat_w, zero fill
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
  // degenerate
  output logic [0:0]                                 m_axis_tuser
);
  import rmq_pkg::*;
  `include "rotation_matrix_to_quaternion_macros.svh"

  localparam int W   = DATA_WIDTH;
  localparam int OB  = ((4 * W + 7) / 8) * 8;
  localparam int CW  = $bits(ctrl_t);
  localparam int PW  = 3 * (W + 1) + CW;
  localparam int FW  = PW + W + 1;
  localparam logic [W-1:0] ONE_W = W'(1) << (W - 2);
  localparam logic signed [W-1:0] NEG_ONE_W = W'(0) - ONE_W;

  logic              front_valid;
  logic [W:0]        front_s;
  logic [2:0][W:0]   front_d;
  ctrl_t             front_ctrl;
  logic              fifo_full;
  logic              fifo_empty;
  logic              push;
  logic              pop;
  logic [FW-1:0]     fifo_dout;
  logic              en;
  logic              sq_valid;
  logic [W-2:0]      sq_root;
  logic [PW-1:0]     sq_pay;
  logic [2:0][W:0]   sq_d;
  ctrl_t             sq_ctrl;
  logic              dv_valid;
  logic [W-2:0]      dv_h;
  ctrl_t             dv_ctrl;
  logic [2:0][W-1:0] dv_q;
  logic [2:0]        dv_ov;
  logic [2:0]        dv_neg;
  logic [3:0][W-1:0] comp;
  logic              degen_c;
  logic [3:0][W-1:0] quat;
  logic              degen;

  rmq_front #(.W(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata[9*W-1:0]),
    .out_valid (front_valid),
    .out_ready (!fifo_full),
    .s_val     (front_s),
    .d_val     (front_d),
    .ctrl      (front_ctrl)
  );

  assign push = front_valid && !fifo_full;

  rmq_fifo #(.FW(FW)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   ({front_ctrl, front_d, front_s}),
    .full  (fifo_full),
    .pop   (pop),
    .dout  (fifo_dout),
    .empty (fifo_empty)
  );

  // Back pipeline steps whenever the output register can take a beat
  assign en  = !m_axis_tvalid || m_axis_tready;
  assign pop = !fifo_empty && en;

  rmq_sqrt #(.W(W), .PW(PW)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pop),
    .n_in      ({1'b0, fifo_dout[W:0], {(W - 4){1'b0}}}),
    .pay_in    (fifo_dout[FW-1:W+1]),
    .out_valid (sq_valid),
    .root_out  (sq_root),
    .pay_out   (sq_pay)
  );

  assign sq_d    = sq_pay[3*(W+1)-1:0];
  assign sq_ctrl = sq_pay[PW-1:3*(W+1)];

  rmq_div #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .h_in      (sq_root),
    .d_in      (sq_d),
    .ctrl_in   (sq_ctrl),
    .out_valid (dv_valid),
    .h_out     (dv_h),
    .ctrl_out  (dv_ctrl),
    .q_out     (dv_q),
    .ov_out    (dv_ov),
    .neg_out   (dv_neg)
  );

  // Place root and quotients in their slots, clamp and sign
  always_comb begin
    logic [1:0]   li;
    logic [W-1:0] mag;
    degen_c = dv_ctrl.degen || (dv_h == '0);
    for (int s = 0; s < 4; s++) begin
      li = 2'(s) - ((2'(s) > dv_ctrl.root) ? 2'd1 : 2'd0);
      if (2'(s) == dv_ctrl.root) begin
        mag     = ({1'b0, dv_h} > ONE_W) ? ONE_W : {1'b0, dv_h};
        comp[s] = mag;
      end else begin
        mag     = (dv_ov[li] || (dv_q[li] > ONE_W)) ? ONE_W : dv_q[li];
        comp[s] = dv_neg[li] ? W'(0) - mag : mag;
      end
      if (degen_c) begin
        comp[s] = '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat  <= comp;
      degen <= degen_c;
    end
  end

  assign m_axis_tdata = OB'(quat);
  assign m_axis_tuser = degen;

  `RMQ_ASSERT_IMPLY(a_degen_zero, m_axis_tvalid && m_axis_tuser[0],
    m_axis_tdata[4*W-1:0] == '0, "degenerate beat carries nonzero components")
  `RMQ_ASSERT_IMPLY(a_x_sat, m_axis_tvalid,
    ($signed(m_axis_tdata[W-1:0]) <= $signed(ONE_W)) &&
    ($signed(m_axis_tdata[W-1:0]) >= NEG_ONE_W), "quat_x beyond unit range")
  `RMQ_ASSERT_IMPLY(a_w_sat, m_axis_tvalid,
    ($signed(m_axis_tdata[4*W-1:3*W]) <= $signed(ONE_W)) &&
    ($signed(m_axis_tdata[4*W-1:3*W]) >= NEG_ONE_W), "quat_w beyond unit range")
  `RMQ_ASSERT_NEXT(a_front_load, s_axis_tvalid && s_axis_tready,
    front_valid, "accepted beat not held in classify stage")

endmodule

// ===== dv/rotation_matrix_to_quaternion_tb.sv =====
module rotation_matrix_to_quaternion_tb;

  localparam int DW = 32;
  localparam int FB = DW - 2;
  localparam int IW = ((9*DW+7)/8)*8;
  localparam int OW = ((4*DW+7)/8)*8;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam int WATCHDOG = 20000;
  localparam int DRAIN = 2*DW + 10;

  typedef struct packed {
    logic         degen;
    logic [DW-1:0] qw;
    logic [DW-1:0] qz;
    logic [DW-1:0] qy;
    logic [DW-1:0] qx;
  } quat_t;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [IW-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [OW-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  quat_t expected_quats[$];
  int errors;
  int idle_cycles;
  int send_idle_pct, recv_stall_pct;

  rotation_matrix_to_quaternion #(.DATA_WIDTH(DW)) i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Integer square root of a 128-bit value
  function automatic longint unsigned isqrt128(logic [127:0] n);
    logic [63:0] res, c;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) res = c;
    end
    return res;
  endfunction

  // d / (4h) in Q1.F, truncated toward zero and saturated
  function automatic longint ratio(longint d, longint unsigned h);
    logic [127:0] num, q;
    longint unsigned mag;
    mag = (d < 0) ? longint'(-d) : d;
    num = {64'd0, mag} << (FB - 2);
    q = num / {64'd0, h};
    if (q > 128'(ONE)) q = 128'(ONE);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp1(longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  // Quaternion from one matrix beat, trace method with pivot fallback
  function automatic quat_t matrix_to_quat(logic [IW-1:0] data);
    longint m[3][3];
    longint q[4];
    longint tr, s;
    longint unsigned h;
    logic dg;
    int i, j, k;
    quat_t r;
    for (int n = 0; n < 9; n++)
      m[n/3][n%3] = longint'($signed(data[n*DW +: DW]));
    q = '{0, 0, 0, 0};
    dg = 1'b0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      h = isqrt128({64'd0, tr + ONE} << (FB - 2));
      if (h == 0) dg = 1'b1;
      else begin
        q[3] = clamp1(h);
        q[0] = ratio(m[2][1] - m[1][2], h);
        q[1] = ratio(m[0][2] - m[2][0], h);
        q[2] = ratio(m[1][0] - m[0][1], h);
      end
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      s = m[i][i] - m[j][j] - m[k][k] + ONE;
      if (s <= 0) dg = 1'b1;
      else begin
        h = isqrt128({64'd0, s} << (FB - 2));
        if (h == 0) dg = 1'b1;
        else begin
          q[i] = clamp1(h);
          q[3] = ratio(m[k][j] - m[j][k], h);
          q[j] = ratio(m[j][i] + m[i][j], h);
          q[k] = ratio(m[k][i] + m[i][k], h);
        end
      end
    end
    r.qx = q[0][DW-1:0];
    r.qy = q[1][DW-1:0];
    r.qz = q[2][DW-1:0];
    r.qw = q[3][DW-1:0];
    r.degen = dg;
    return r;
  endfunction

  function automatic logic [IW-1:0] pack9(longint e[9]);
    logic [IW-1:0] d;
    d = '0;
    for (int n = 0; n < 9; n++) d[n*DW +: DW] = e[n][DW-1:0];
    return d;
  endfunction

  // Element near a typical rotation value, occasionally an extreme or raw pattern
  function automatic longint rand_elem();
    case ($urandom_range(0, 9))
      0: return ONE;
      1: return -ONE;
      2: return longint'($signed($urandom()));
      3: return 0;
      default: return longint'($urandom_range(0, 2*ONE)) - ONE;
    endcase
  endfunction

  // Rotation-like matrix about a random axis with sign flips, or random elements
  function automatic logic [IW-1:0] rand_matrix();
    longint e[9];
    longint c, s, noise;
    int ax;
    if ($urandom_range(0, 3) == 0) begin
      for (int n = 0; n < 9; n++) e[n] = rand_elem();
      return pack9(e);
    end
    c = longint'($urandom_range(0, 2*ONE)) - ONE;
    s = longint'($urandom_range(0, ONE));
    if ($urandom_range(0, 1)) s = -s;
    ax = $urandom_range(0, 2);
    for (int n = 0; n < 9; n++) e[n] = 0;
    e[ax*4] = ONE;
    e[((ax+1)%3)*4] = c;
    e[((ax+2)%3)*4] = c;
    e[((ax+1)%3)*3 + (ax+2)%3] = -s;
    e[((ax+2)%3)*3 + (ax+1)%3] = s;
    if ($urandom_range(0, 3) == 0) begin
      e[ax*4] = -ONE;
      e[((ax+1)%3)*4] = -c;
    end
    for (int n = 0; n < 9; n++) begin
      noise = longint'($urandom_range(0, 2000)) - 1000;
      if ($urandom_range(0, 1)) e[n] = e[n] + noise;
    end
    return pack9(e);
  endfunction

  // Send one matrix beat under the current sender idle rate
  task automatic send_matrix(logic [IW-1:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_quats.push_back(matrix_to_quat(data));
  endtask

  // Receiver stall pattern
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare every output beat with the oldest expectation
  always @(posedge clk) begin
    quat_t got, exp_q;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser[0], m_axis_tdata[4*DW-1:0]};
      if (expected_quats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, actual %h", $time, got);
      end else begin
        exp_q = expected_quats.pop_front();
        if (got.qx !== exp_q.qx)
          $display("%0t: quat_x expected %h actual %h", $time, exp_q.qx, got.qx);
        if (got.qy !== exp_q.qy)
          $display("%0t: quat_y expected %h actual %h", $time, exp_q.qy, got.qy);
        if (got.qz !== exp_q.qz)
          $display("%0t: quat_z expected %h actual %h", $time, exp_q.qz, got.qz);
        if (got.qw !== exp_q.qw)
          $display("%0t: quat_w expected %h actual %h", $time, exp_q.qw, got.qw);
        if (got.degen !== exp_q.degen)
          $display("%0t: degenerate expected %b actual %b", $time, exp_q.degen, got.degen);
        if (got !== exp_q) errors++;
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (s_axis_tvalid || expected_quats.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("rotation_matrix_to_quaternion: mismatch");
        $finish;
      end
    end
  end

  // Directed rows: identity, half and quarter turns, zero, negated identity and extremes
  localparam int N_DIR = 12;
  longint dir_rows[N_DIR][9];
  logic   dir_known[N_DIR];
  quat_t  dir_quat[N_DIR];

  initial begin
    errors = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;

    dir_rows[0]  = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    dir_rows[1]  = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};
    dir_rows[2]  = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};
    dir_rows[3]  = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};
    dir_rows[4]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    dir_rows[5]  = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};
    dir_rows[6]  = '{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE};
    dir_rows[7]  = '{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE};
    dir_rows[8]  = '{-ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE};
    dir_rows[9]  = '{-2*ONE, 2*ONE-1, -2*ONE, 2*ONE-1,
                     -2*ONE, 2*ONE-1, -2*ONE, 2*ONE-1, 0};
    dir_rows[10] = '{2*ONE-1, -2*ONE, 2*ONE-1, -2*ONE,
                     2*ONE-1, -2*ONE, 2*ONE-1, -2*ONE, 2*ONE-1};
    dir_rows[11] = '{0, 0, 0, 0, 0, -ONE, 0, ONE, 0};
    for (int n = 0; n < N_DIR; n++) dir_known[n] = 1'b0;
    // identity and axis half turns read off directly
    dir_known[0] = 1'b1; dir_quat[0] = '{1'b0, DW'(ONE), '0, '0, '0};
    dir_known[1] = 1'b1; dir_quat[1] = '{1'b0, '0, '0, '0, DW'(ONE)};
    dir_known[2] = 1'b1; dir_quat[2] = '{1'b0, '0, '0, DW'(ONE), '0};
    dir_known[3] = 1'b1; dir_quat[3] = '{1'b0, '0, DW'(ONE), '0, '0};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int n = 0; n < N_DIR; n++) begin
      if (dir_known[n] && matrix_to_quat(pack9(dir_rows[n])) !== dir_quat[n]) begin
        errors++;
        $display("%0t: row %0d expected %h predicted %h", $time, n, dir_quat[n],
                 matrix_to_quat(pack9(dir_rows[n])));
      end
      send_matrix(pack9(dir_rows[n]));
    end

    // Random phases: free flow, sender idle, receiver stall, both
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        3: begin send_idle_pct = 15; recv_stall_pct = 15; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 260; n++) send_matrix(rand_matrix());
    end
    s_axis_tvalid <= 1'b0;

    recv_stall_pct = 0;
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0)
      $display("rotation_matrix_to_quaternion: match");
    else
      $display("rotation_matrix_to_quaternion: mismatch");
    $finish;
  end

endmodule
